// File: hdl/gtdb_pkg.sv
// Shared types and constants for the graph traversal block.
`timescale 1ns / 1ps
`default_nettype none

package gtdb_pkg;

    localparam int VERTEX_W   = 4;
    localparam int ROW_W      = 16;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE   = 1'b1;

    localparam logic FUNC_LOAD_ROW = 1'b0;
    localparam logic FUNC_START    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_BAD,
        ST_DFS,
        ST_BFS,
        ST_FLUSH
    } gtdb_state_t;

    typedef struct packed {
        logic load_row;
        logic capture_start;
        logic init_walk;
        logic emit_bad;
        logic dfs_push;
        logic dfs_pop;
        logic bfs_enqueue;
        logic bfs_pop;
        logic flush;
    } gtdb_cmd_t;

    typedef struct packed {
        logic bad_start;
        logic mode_bfs;
        logic cand_any;
        logic stack_empty;
        logic queue_empty;
        logic out_free;
    } gtdb_status_t;

endpackage

`default_nettype wire

// File: hdl/gtdb_ctrl.sv
// Controller state machine for the graph traversal block.
`timescale 1ns / 1ps
`default_nettype none

module gtdb_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tuser,
    output logic                      s_tready,
    input  wire gtdb_pkg::gtdb_status_t status,
    output gtdb_pkg::gtdb_cmd_t       cmd
);
    import gtdb_pkg::*;

    gtdb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == FUNC_START) state_next = ST_START;
            end
            ST_START: begin
                if (status.bad_start) state_next = ST_BAD;
                else if (status.mode_bfs) state_next = ST_BFS;
                else state_next = ST_DFS;
            end
            ST_BAD: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_DFS: begin
                if (status.stack_empty) state_next = ST_FLUSH;
            end
            ST_BFS: begin
                if (!status.cand_any && status.queue_empty) state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready          = 1'b1;
                cmd.load_row      = s_tvalid && s_tuser == FUNC_LOAD_ROW;
                cmd.capture_start = s_tvalid && s_tuser == FUNC_START;
            end
            ST_START: begin
                cmd.init_walk = !status.bad_start;
            end
            ST_BAD: begin
                cmd.emit_bad = status.out_free;
            end
            ST_DFS: begin
                if (!status.stack_empty && status.out_free) begin
                    cmd.dfs_push = status.cand_any;
                    cmd.dfs_pop  = !status.cand_any;
                end
            end
            ST_BFS: begin
                cmd.bfs_enqueue = status.cand_any;
                cmd.bfs_pop     = !status.cand_any && !status.queue_empty && status.out_free;
            end
            ST_FLUSH: begin
                cmd.flush = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("ready raised outside idle");
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.dfs_push, cmd.dfs_pop, cmd.bfs_enqueue, cmd.bfs_pop,
                    cmd.flush, cmd.emit_bad}) <= 1)
        else $error("more than one walk step in a cycle");
    a_start_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture_start |=> state_reg == ST_START)
        else $error("start item not followed by setup");
`endif

endmodule

`default_nettype wire

// File: hdl/gtdb_datapath.sv
// Datapath of the graph traversal block: adjacency rows, marks, walk buffer, output register.
`timescale 1ns / 1ps
`default_nettype none

module gtdb_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [gtdb_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                               cfg_valid,
    input  wire logic [gtdb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gtdb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [gtdb_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                    m_tlast,
    output logic                                    m_tuser,
    input  wire gtdb_pkg::gtdb_cmd_t                cmd,
    output gtdb_pkg::gtdb_status_t                  status
);
    import gtdb_pkg::*;

    localparam int VCAP = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int AW   = $clog2(VCAP);
    localparam int CW   = $clog2(VCAP + 1);

    logic [ROW_W-1:0]    adj_reg [VCAP];
    logic [VERTEX_W-1:0] walk_reg [VCAP];
    logic [ROW_W-1:0]    visited_reg, visited_next;
    logic [CW-1:0]       depth_reg, depth_next;
    logic [CW-1:0]       head_reg, head_next;
    logic [CW-1:0]       tail_reg, tail_next;
    logic [VERTEX_W-1:0] cur_reg, cur_next;
    logic [VERTEX_W-1:0] pend_reg, pend_next;
    logic [VERTEX_W-1:0] start_reg;
    logic [COUNT_W-1:0]  vcount_reg;
    logic                mode_reg;
    logic                out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0] out_vertex_reg, out_vertex_next;
    logic                out_last_reg, out_last_next;
    logic                out_bad_reg, out_bad_next;

    logic [VERTEX_W-1:0] in_row_index;
    logic [ROW_W-1:0]    in_row_bits;
    logic [VERTEX_W-1:0] in_start;
    logic                row_ok;
    logic [COUNT_W-1:0]  n_active;
    logic [ROW_W-1:0]    vmask;
    logic [ROW_W-1:0]    cand_bits;
    logic [VERTEX_W-1:0] cand_idx;
    logic [CW-1:0]       depth_m2;
    logic                emit;

    assign in_row_index = s_tdata[3:0];
    assign in_row_bits  = s_tdata[19:4];
    assign in_start     = s_tdata[23:20];
    assign row_ok       = {1'b0, in_row_index} < COUNT_W'(VCAP);

    assign n_active = (vcount_reg > COUNT_W'(VCAP)) ? COUNT_W'(VCAP) : vcount_reg;

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            vmask[j] = COUNT_W'(j) < n_active;
        end
    end

    // Lowest-numbered unvisited neighbor of the current vertex.
    assign cand_bits = adj_reg[cur_reg[AW-1:0]] & ~visited_reg & vmask;
    always_comb begin
        cand_idx = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (cand_bits[j]) cand_idx = VERTEX_W'(j);
        end
    end

    assign depth_m2 = depth_reg - CW'(2);
    assign emit = cmd.dfs_push || cmd.bfs_pop || cmd.flush || cmd.emit_bad;

    assign status.bad_start   = {1'b0, start_reg} >= n_active;
    assign status.mode_bfs    = mode_reg;
    assign status.cand_any    = |cand_bits;
    assign status.stack_empty = depth_reg == '0;
    assign status.queue_empty = head_reg >= tail_reg;
    assign status.out_free    = !out_valid_reg || m_tready;

    always_comb begin
        visited_next    = visited_reg;
        depth_next      = depth_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        out_valid_next  = (out_valid_reg && !m_tready) || emit;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;
        if (cmd.init_walk) begin
            visited_next = ROW_W'(1) << start_reg;
            depth_next   = CW'(1);
            head_next    = '0;
            tail_next    = '0;
            cur_next     = start_reg;
            pend_next    = start_reg;
        end
        if (cmd.dfs_push) begin
            visited_next = visited_reg | (ROW_W'(1) << cand_idx);
            depth_next   = depth_reg + CW'(1);
            cur_next     = cand_idx;
            pend_next    = cand_idx;
        end
        if (cmd.dfs_pop) begin
            depth_next = depth_reg - CW'(1);
            cur_next   = walk_reg[depth_m2[AW-1:0]];
        end
        if (cmd.bfs_enqueue) begin
            visited_next = visited_reg | (ROW_W'(1) << cand_idx);
            tail_next    = tail_reg + CW'(1);
        end
        if (cmd.bfs_pop) begin
            head_next = head_reg + CW'(1);
            cur_next  = walk_reg[head_reg[AW-1:0]];
            pend_next = walk_reg[head_reg[AW-1:0]];
        end
        if (cmd.dfs_push || cmd.bfs_pop || cmd.flush) begin
            out_vertex_next = pend_reg;
            out_last_next   = cmd.flush;
            out_bad_next    = 1'b0;
        end
        if (cmd.emit_bad) begin
            out_vertex_next = start_reg;
            out_last_next   = 1'b1;
            out_bad_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VCAP; i++) begin
                adj_reg[i] <= '0;
            end
            visited_reg   <= '0;
            depth_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            vcount_reg    <= COUNT_W'(16);
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_row && row_ok) adj_reg[in_row_index[AW-1:0]] <= in_row_bits;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vcount_reg <= cfg_data;
                    CFG_ORDER_MODE:   mode_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            visited_reg   <= visited_next;
            depth_reg     <= depth_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_start) start_reg <= in_start;
        if (cmd.init_walk) walk_reg[0] <= start_reg;
        if (cmd.dfs_push) walk_reg[depth_reg[AW-1:0]] <= cand_idx;
        if (cmd.bfs_enqueue) walk_reg[tail_reg[AW-1:0]] <= cand_idx;
        cur_reg        <= cur_next;
        pend_reg       <= pend_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
        out_bad_reg    <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - VERTEX_W){1'b0}}, out_vertex_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !emit)
        else $error("result overwritten before it was taken");
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CW'(VCAP))
        else $error("stack depth beyond capacity");
    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg && tail_reg <= CW'(VCAP))
        else $error("queue pointers out of order");
    a_bad_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_bad |=> m_tvalid && m_tlast && m_tuser)
        else $error("bad start result malformed");
`endif

endmodule

`default_nettype wire

// File: hdl/graph_traversal_dfs_bfs.sv
// Top level of the adjacency-matrix depth-first and breadth-first traversal block.
`timescale 1ns / 1ps
`default_nettype none

// The block holds one 16-bit adjacency row per vertex. An input item with tuser low
// loads a row and gives no result; an item with tuser high starts a walk
// from the given vertex, clears the visited marks, and streams the reached vertices out
// in traversal order with tlast on the final one. Depth-first mode (order_mode 0) always
// descends into the lowest-numbered unvisited neighbor; breadth-first mode (order_mode 1)
// queues neighbors in ascending order. A start vertex not below the active vertex count
// gives a single item with tuser set. One walk step runs per cycle unless the result
// side holds it, through a single neighbor-select unit: a start item is captured in
// idle and checked and set up in the start state, then depth-first takes one push or
// pop per step and breadth-first one enqueue or dequeue per step, and a flush step
// releases the last item. The block takes a new item only when the previous walk has
// finished; its last result may still be waiting in the output register. Configuration
// writes are taken at any time but belong between walks.
module graph_traversal_dfs_bfs #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: row_index [3:0], row_bits [19:4], start_vertex [23:20].
    input  wire logic [23:0] s_tdata,
    // s_tuser: func (0 load row, 1 start walk).
    input  wire logic        s_tuser,
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: vertex [3:0], zero fill [7:4].
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    // m_tuser: bad_start.
    output logic             m_tuser,
    // Configuration writes: index 0 vertex_count, index 1 order_mode.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);
    import gtdb_pkg::*;

    gtdb_cmd_t    cmd;
    gtdb_status_t status;

    // Register writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    gtdb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gtdb_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
